@@ src/lpcc_pkg.sv @@
// Shared types, constants and tables of the LCh pixel colour classifier.
package lpcc_pkg;

   localparam int FRAC_BITS = 7;

   localparam int LUM_W  = 15;
   localparam int CHR_W  = 15;
   localparam int HUE_W  = 16;
   localparam int THR_W  = 15;
   localparam int SF_W   = 6;
   localparam int KIND_W = 2;
   localparam int MASK_W = 6;
   localparam int HSEC_W = 4;
   localparam int LSEC_W = 3;
   localparam int LINT_W = LUM_W - FRAC_BITS;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAY_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIN_FACTOR    = 8'd1;
   localparam logic [THR_W-1:0] GRAY_THRESHOLD_RESET = 15'd256;
   localparam logic [SF_W-1:0]  SKIN_FACTOR_RESET    = 6'd24;

   // CORDIC gain compensation, 2^-16 units
   localparam int GAIN_W = 17;
   localparam logic signed [GAIN_W-1:0] GAIN = 17'sd39797;

   localparam int XW         = 34;
   localparam int ZW         = 34;
   localparam int ATAN_COUNT = 20;
   localparam int BOX_COUNT  = 16;
   localparam int BW         = 16;
   localparam int CW_L       = 32;
   localparam int CW_AB      = 48;

   localparam int LINT_LIMIT = 100;
   localparam int LSEC_STEP  = 20;

   typedef enum logic [KIND_W-1:0] {
      KIND_GRAY,
      KIND_SKIN,
      KIND_SECTOR,
      KIND_NONE
   } class_kind_type;

   typedef struct packed {
      logic                gray;
      logic                l_ge100;
      logic [HSEC_W-1:0]   hue_sector;
      logic [LSEC_W-1:0]   l_sector;
      logic [LUM_W-1:0]    lightness;
   } side_type;

   // box limits held in tenths
   typedef struct packed {
      logic [2:0] group;
      logic [9:0] l_avg;
      logic [5:0] l_sd;
      logic [9:0] a_avg;
      logic [5:0] a_sd;
      logic [9:0] b_avg;
      logic [5:0] b_sd;
   } box_type;

   // atan(2^-i), 2^32 units per turn
   function automatic logic signed [ZW-1:0] atan_angle(input int idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0:       r = 34'sd536870912;
         1:       r = 34'sd316933406;
         2:       r = 34'sd167458907;
         3:       r = 34'sd85004756;
         4:       r = 34'sd42667331;
         5:       r = 34'sd21354465;
         6:       r = 34'sd10679838;
         7:       r = 34'sd5340245;
         8:       r = 34'sd2670163;
         9:       r = 34'sd1335087;
         10:      r = 34'sd667544;
         11:      r = 34'sd333772;
         12:      r = 34'sd166886;
         13:      r = 34'sd83443;
         14:      r = 34'sd41722;
         15:      r = 34'sd20861;
         16:      r = 34'sd10430;
         17:      r = 34'sd5215;
         18:      r = 34'sd2608;
         19:      r = 34'sd1304;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic box_type skin_box(input int idx);
      box_type r;
      case (idx)
         0:       r = '{3'd0, 10'd609, 6'd34, 10'd70,  6'd17, 10'd150, 6'd18};
         1:       r = '{3'd1, 10'd619, 6'd37, 10'd71,  6'd17, 10'd174, 6'd20};
         2:       r = '{3'd2, 10'd606, 6'd48, 10'd65,  6'd16, 10'd164, 6'd23};
         3:       r = '{3'd3, 10'd630, 6'd55, 10'd56,  6'd19, 10'd140, 6'd29};
         4:       r = '{3'd0, 10'd564, 6'd32, 10'd117, 6'd21, 10'd163, 6'd14};
         5:       r = '{3'd1, 10'd568, 6'd41, 10'd116, 6'd22, 10'd177, 6'd18};
         6:       r = '{3'd2, 10'd561, 6'd45, 10'd113, 6'd21, 10'd164, 6'd22};
         7:       r = '{3'd3, 10'd592, 6'd51, 10'd116, 6'd28, 10'd151, 6'd23};
         8:       r = '{3'd4, 10'd440, 6'd20, 10'd140, 6'd10, 10'd190, 6'd10};
         9:       r = '{3'd5, 10'd580, 6'd10, 10'd150, 6'd10, 10'd210, 6'd10};
         10:      r = '{3'd0, 10'd589, 6'd31, 10'd114, 6'd21, 10'd142, 6'd15};
         11:      r = '{3'd1, 10'd607, 6'd40, 10'd105, 6'd23, 10'd172, 6'd21};
         12:      r = '{3'd2, 10'd580, 6'd44, 10'd117, 6'd23, 10'd158, 6'd21};
         13:      r = '{3'd3, 10'd596, 6'd55, 10'd118, 6'd31, 10'd146, 6'd26};
         14:      r = '{3'd4, 10'd480, 6'd10, 10'd150, 6'd10, 10'd200, 6'd10};
         15:      r = '{3'd5, 10'd630, 6'd10, 10'd160, 6'd10, 10'd210, 6'd10};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ src/lpcc_front.sv @@
// Input skid slot, capture stage and pre-rotation stage (gray test, fold, gain multiply).
module lpcc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lpcc_pkg::LUM_W-1:0]            req_lightness,
   input  logic [lpcc_pkg::CHR_W-1:0]            req_chroma,
   input  logic [lpcc_pkg::HUE_W-1:0]            req_hue,
   input  logic [lpcc_pkg::THR_W-1:0]            gray_threshold,
   output logic                                  dst_valid,
   output logic signed [lpcc_pkg::XW-1:0]        dst_x,
   output logic signed [lpcc_pkg::ZW-1:0]        dst_z,
   output lpcc_pkg::side_type                    dst_side
);

   logic                         accept;
   logic                         skid_valid_ff, skid_valid_in;
   logic [lpcc_pkg::LUM_W-1:0]   skid_lum_ff;
   logic [lpcc_pkg::CHR_W-1:0]   skid_chr_ff;
   logic [lpcc_pkg::HUE_W-1:0]   skid_hue_ff;

   logic                         a_valid_ff, a_valid_in;
   logic [lpcc_pkg::LUM_W-1:0]   a_lum_ff, a_lum_in;
   logic [lpcc_pkg::CHR_W-1:0]   a_chr_ff, a_chr_in;
   logic [lpcc_pkg::HUE_W-1:0]   a_hue_ff, a_hue_in;

   logic                                b_valid_ff;
   logic signed [lpcc_pkg::XW-1:0]      b_x_ff, b_x_in;
   logic signed [lpcc_pkg::ZW-1:0]      b_z_ff, b_z_in;
   lpcc_pkg::side_type                  b_side_ff, b_side_in;

   logic                                fold;
   logic signed [lpcc_pkg::GAIN_W-1:0]  chr_s;
   logic [lpcc_pkg::HUE_W-1:0]          hue_f;
   logic [lpcc_pkg::HUE_W+3:0]          hue15;
   logic [lpcc_pkg::LINT_W-1:0]         lint;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   // skid slot parks a word taken while the pipe is held
   assign skid_valid_in = advance ? 1'b0 : (skid_valid_ff || accept);

   always_comb begin
      a_valid_in = skid_valid_ff || accept;
      if (skid_valid_ff) begin
         a_lum_in = skid_lum_ff;
         a_chr_in = skid_chr_ff;
         a_hue_in = skid_hue_ff;
      end else begin
         a_lum_in = req_lightness;
         a_chr_in = req_chroma;
         a_hue_in = req_hue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      if (!skid_valid_ff) begin
         skid_lum_ff <= req_lightness;
         skid_chr_ff <= req_chroma;
         skid_hue_ff <= req_hue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         a_lum_ff  <= a_lum_in;
         a_chr_ff  <= a_chr_in;
         a_hue_ff  <= a_hue_in;
         b_x_ff    <= b_x_in;
         b_z_ff    <= b_z_in;
         b_side_ff <= b_side_in;
      end
   end

   // fold hue into +-90 degrees: half-turn flip and negated start vector
   always_comb begin
      fold  = (a_hue_ff[15:14] == 2'b01 && a_hue_ff[13:0] != '0) || a_hue_ff[15:14] == 2'b10;
      chr_s = fold ? -$signed({2'b00, a_chr_ff}) : $signed({2'b00, a_chr_ff});
      hue_f = {a_hue_ff[15] ^ fold, a_hue_ff[14:0]};
      hue15 = {a_hue_ff, 4'b0000} - {4'b0000, a_hue_ff};
      lint  = a_lum_ff[lpcc_pkg::LUM_W-1:lpcc_pkg::FRAC_BITS];

      b_x_in = lpcc_pkg::XW'(chr_s) * lpcc_pkg::XW'(lpcc_pkg::GAIN);
      b_z_in = {{(lpcc_pkg::ZW-32){hue_f[15]}}, hue_f, 16'h0000};

      b_side_in.gray       = a_chr_ff < gray_threshold;
      b_side_in.l_ge100    = 32'(lint) >= 32'(lpcc_pkg::LINT_LIMIT);
      b_side_in.hue_sector = hue15[lpcc_pkg::HUE_W+3:lpcc_pkg::HUE_W];
      b_side_in.lightness  = a_lum_ff;
      if (32'(lint) >= 32'(4 * lpcc_pkg::LSEC_STEP)) begin
         b_side_in.l_sector = 3'd4;
      end else if (32'(lint) >= 32'(3 * lpcc_pkg::LSEC_STEP)) begin
         b_side_in.l_sector = 3'd3;
      end else if (32'(lint) >= 32'(2 * lpcc_pkg::LSEC_STEP)) begin
         b_side_in.l_sector = 3'd2;
      end else if (32'(lint) >= 32'(lpcc_pkg::LSEC_STEP)) begin
         b_side_in.l_sector = 3'd1;
      end else begin
         b_side_in.l_sector = 3'd0;
      end
   end

   assign dst_valid = b_valid_ff;
   assign dst_x     = b_x_ff;
   assign dst_z     = b_z_ff;
   assign dst_side  = b_side_ff;

   a_park: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !advance |=> req_stall)
      else $error("word taken during hold not parked");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && advance |=> a_valid_ff && !skid_valid_ff)
      else $error("parked word lost on release");

endmodule

@@ src/lpcc_cordic.sv @@
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module lpcc_cordic #(
   parameter int STEPS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              src_valid,
   input  logic signed [lpcc_pkg::XW-1:0]    src_x,
   input  logic signed [lpcc_pkg::ZW-1:0]    src_z,
   input  lpcc_pkg::side_type                src_side,
   output logic                              dst_valid,
   output logic signed [lpcc_pkg::XW-1:0]    dst_x,
   output logic signed [lpcc_pkg::XW-1:0]    dst_y,
   output lpcc_pkg::side_type                dst_side
);

   logic                             valid_ff [STEPS];
   logic signed [lpcc_pkg::XW-1:0]   x_ff     [STEPS];
   logic signed [lpcc_pkg::XW-1:0]   y_ff     [STEPS];
   lpcc_pkg::side_type               side_ff  [STEPS];
   logic signed [lpcc_pkg::XW-1:0]   x_in     [STEPS];
   logic signed [lpcc_pkg::XW-1:0]   y_in     [STEPS];
   logic                             valid_in [STEPS];
   lpcc_pkg::side_type               side_in  [STEPS];
   logic signed [lpcc_pkg::ZW-1:0]   z_ff     [STEPS-1];
   logic signed [lpcc_pkg::ZW-1:0]   z_in     [STEPS-1];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic signed [lpcc_pkg::XW-1:0] xi, yi;
      logic signed [lpcc_pkg::ZW-1:0] zi;

      if (i == 0) begin : g_head
         assign xi          = src_x;
         assign yi          = '0;
         assign zi          = src_z;
         assign valid_in[i] = src_valid;
         assign side_in[i]  = src_side;
      end else begin : g_body
         assign xi          = x_ff[i-1];
         assign yi          = y_ff[i-1];
         assign zi          = z_ff[i-1];
         assign valid_in[i] = valid_ff[i-1];
         assign side_in[i]  = side_ff[i-1];
      end

      assign x_in[i] = zi[lpcc_pkg::ZW-1] ? xi + (yi >>> i) : xi - (yi >>> i);
      assign y_in[i] = zi[lpcc_pkg::ZW-1] ? yi - (xi >>> i) : yi + (xi >>> i);

      if (i < STEPS - 1) begin : g_angle
         assign z_in[i] = zi[lpcc_pkg::ZW-1] ? zi + lpcc_pkg::atan_angle(i)
                                              : zi - lpcc_pkg::atan_angle(i);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            side_ff[i] <= side_in[i];
         end
         for (int i = 0; i < STEPS - 1; i++) begin
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign dst_valid = valid_ff[STEPS-1];
   assign dst_x     = x_ff[STEPS-1];
   assign dst_y     = y_ff[STEPS-1];
   assign dst_side  = side_ff[STEPS-1];

endmodule

@@ src/lpcc_box.sv @@
// Skin box test: bound registers, scaling stage and compare stage.
module lpcc_box (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [lpcc_pkg::SF_W-1:0]           skin_factor,
   input  logic                                src_valid,
   input  logic signed [lpcc_pkg::XW-1:0]      src_x,
   input  logic signed [lpcc_pkg::XW-1:0]      src_y,
   input  lpcc_pkg::side_type                  src_side,
   output logic                                dst_valid,
   output logic [lpcc_pkg::BOX_COUNT-1:0]      dst_match,
   output lpcc_pkg::side_type                  dst_side
);

   // 16*avg -+ sf*std, tenths x16
   logic signed [lpcc_pkg::BW-1:0] l_lo_ff [lpcc_pkg::BOX_COUNT];
   logic signed [lpcc_pkg::BW-1:0] l_hi_ff [lpcc_pkg::BOX_COUNT];
   logic signed [lpcc_pkg::BW-1:0] a_lo_ff [lpcc_pkg::BOX_COUNT];
   logic signed [lpcc_pkg::BW-1:0] a_hi_ff [lpcc_pkg::BOX_COUNT];
   logic signed [lpcc_pkg::BW-1:0] b_lo_ff [lpcc_pkg::BOX_COUNT];
   logic signed [lpcc_pkg::BW-1:0] b_hi_ff [lpcc_pkg::BOX_COUNT];

   logic                                 w_valid_ff;
   logic signed [lpcc_pkg::CW_L-1:0]     w_l_ff, w_l_in, lum_ext;
   logic signed [lpcc_pkg::CW_AB-1:0]    w_a_ff, w_a_in, w_b_ff, w_b_in, a_ext, b_ext;
   lpcc_pkg::side_type                   w_side_ff;

   logic                                 m_valid_ff;
   logic [lpcc_pkg::BOX_COUNT-1:0]       m_match_ff, m_match_in;
   lpcc_pkg::side_type                   m_side_ff;

   always_ff @(posedge clock) begin
      for (int b = 0; b < lpcc_pkg::BOX_COUNT; b++) begin
         l_lo_ff[b] <= lpcc_pkg::BW'({lpcc_pkg::skin_box(b).l_avg, 4'b0000})
                     - lpcc_pkg::BW'(skin_factor) * lpcc_pkg::BW'(lpcc_pkg::skin_box(b).l_sd);
         l_hi_ff[b] <= lpcc_pkg::BW'({lpcc_pkg::skin_box(b).l_avg, 4'b0000})
                     + lpcc_pkg::BW'(skin_factor) * lpcc_pkg::BW'(lpcc_pkg::skin_box(b).l_sd);
         a_lo_ff[b] <= lpcc_pkg::BW'({lpcc_pkg::skin_box(b).a_avg, 4'b0000})
                     - lpcc_pkg::BW'(skin_factor) * lpcc_pkg::BW'(lpcc_pkg::skin_box(b).a_sd);
         a_hi_ff[b] <= lpcc_pkg::BW'({lpcc_pkg::skin_box(b).a_avg, 4'b0000})
                     + lpcc_pkg::BW'(skin_factor) * lpcc_pkg::BW'(lpcc_pkg::skin_box(b).a_sd);
         b_lo_ff[b] <= lpcc_pkg::BW'({lpcc_pkg::skin_box(b).b_avg, 4'b0000})
                     - lpcc_pkg::BW'(skin_factor) * lpcc_pkg::BW'(lpcc_pkg::skin_box(b).b_sd);
         b_hi_ff[b] <= lpcc_pkg::BW'({lpcc_pkg::skin_box(b).b_avg, 4'b0000})
                     + lpcc_pkg::BW'(skin_factor) * lpcc_pkg::BW'(lpcc_pkg::skin_box(b).b_sd);
      end
   end

   // value x160, bounds carry the 2^F and 2^(F+16) units as shifts
   always_comb begin
      lum_ext = lpcc_pkg::CW_L'(src_side.lightness);
      a_ext   = lpcc_pkg::CW_AB'(src_x);
      b_ext   = lpcc_pkg::CW_AB'(src_y);
      w_l_in  = (lum_ext <<< 7) + (lum_ext <<< 5);
      w_a_in  = (a_ext <<< 7) + (a_ext <<< 5);
      w_b_in  = (b_ext <<< 7) + (b_ext <<< 5);
   end

   always_comb begin
      for (int b = 0; b < lpcc_pkg::BOX_COUNT; b++) begin
         m_match_in[b] =
            (w_l_ff > (lpcc_pkg::CW_L'(l_lo_ff[b]) <<< lpcc_pkg::FRAC_BITS)) &&
            (w_l_ff < (lpcc_pkg::CW_L'(l_hi_ff[b]) <<< lpcc_pkg::FRAC_BITS)) &&
            (w_a_ff > (lpcc_pkg::CW_AB'(a_lo_ff[b]) <<< (lpcc_pkg::FRAC_BITS + 16))) &&
            (w_a_ff < (lpcc_pkg::CW_AB'(a_hi_ff[b]) <<< (lpcc_pkg::FRAC_BITS + 16))) &&
            (w_b_ff > (lpcc_pkg::CW_AB'(b_lo_ff[b]) <<< (lpcc_pkg::FRAC_BITS + 16))) &&
            (w_b_ff < (lpcc_pkg::CW_AB'(b_hi_ff[b]) <<< (lpcc_pkg::FRAC_BITS + 16)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         w_valid_ff <= src_valid;
         m_valid_ff <= w_valid_ff;
      end
      if (advance) begin
         w_l_ff     <= w_l_in;
         w_a_ff     <= w_a_in;
         w_b_ff     <= w_b_in;
         w_side_ff  <= src_side;
         m_match_ff <= m_match_in;
         m_side_ff  <= w_side_ff;
      end
   end

   assign dst_valid = m_valid_ff;
   assign dst_match = m_match_ff;
   assign dst_side  = m_side_ff;

endmodule

@@ src/lch_pixel_color_classifier.sv @@
// Top level: register port, pipeline chain and result register of the LCh classifier.
// An accepted req word runs through the capture, pre-rotation, CORDIC, box scaling and
//   compare stages and the result register to rsp_valid, via the skid slot if it waited.
// Throughput: one word per cycle unless held; depth: CORDIC pipe, one rotation per stage.
// Pipe holds only while a result waits under rsp_stall; req_stall is registered.
// Reset clears all valid bits and loads gray_threshold 256 and skin_factor 24.
module lch_pixel_color_classifier #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lpcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lpcc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lpcc_pkg::LUM_W-1:0]            req_lightness,
   input  logic [lpcc_pkg::CHR_W-1:0]            req_chroma,
   input  logic [lpcc_pkg::HUE_W-1:0]            req_hue,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lpcc_pkg::KIND_W-1:0]           rsp_class_kind,
   output logic [lpcc_pkg::MASK_W-1:0]           rsp_skin_mask,
   output logic [lpcc_pkg::HSEC_W-1:0]           rsp_hue_sector,
   output logic [lpcc_pkg::LSEC_W-1:0]           rsp_lightness_sector
);

   logic [lpcc_pkg::THR_W-1:0]       gray_thr_ff;
   logic [lpcc_pkg::SF_W-1:0]        skin_factor_ff;
   logic                             advance;

   logic                             f_valid;
   logic signed [lpcc_pkg::XW-1:0]   f_x;
   logic signed [lpcc_pkg::ZW-1:0]   f_z;
   lpcc_pkg::side_type               f_side;

   logic                             c_valid;
   logic signed [lpcc_pkg::XW-1:0]   c_x, c_y;
   lpcc_pkg::side_type               c_side;

   logic                             m_valid;
   logic [lpcc_pkg::BOX_COUNT-1:0]   m_match;
   lpcc_pkg::side_type               m_side;

   logic                             rsp_valid_ff;
   lpcc_pkg::class_kind_type         kind_ff, kind_in;
   logic [lpcc_pkg::MASK_W-1:0]      mask_ff, mask_in, group_mask;
   logic [lpcc_pkg::HSEC_W-1:0]      hsec_ff, hsec_in;
   logic [lpcc_pkg::LSEC_W-1:0]      lsec_ff, lsec_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_thr_ff    <= lpcc_pkg::GRAY_THRESHOLD_RESET;
         skin_factor_ff <= lpcc_pkg::SKIN_FACTOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lpcc_pkg::CSR_GRAY_THRESHOLD: begin
               gray_thr_ff <= csr_wdata[lpcc_pkg::THR_W-1:0];
            end
            lpcc_pkg::CSR_SKIN_FACTOR: begin
               skin_factor_ff <= csr_wdata[lpcc_pkg::SF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance = !rsp_valid_ff || !rsp_stall;

   lpcc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_lightness  (req_lightness),
      .req_chroma     (req_chroma),
      .req_hue        (req_hue),
      .gray_threshold (gray_thr_ff),
      .dst_valid      (f_valid),
      .dst_x          (f_x),
      .dst_z          (f_z),
      .dst_side       (f_side)
   );

   lpcc_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .src_valid (f_valid),
      .src_x     (f_x),
      .src_z     (f_z),
      .src_side  (f_side),
      .dst_valid (c_valid),
      .dst_x     (c_x),
      .dst_y     (c_y),
      .dst_side  (c_side)
   );

   lpcc_box u_box (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .skin_factor (skin_factor_ff),
      .src_valid   (c_valid),
      .src_x       (c_x),
      .src_y       (c_y),
      .src_side    (c_side),
      .dst_valid   (m_valid),
      .dst_match   (m_match),
      .dst_side    (m_side)
   );

   always_comb begin
      group_mask = '0;
      for (int b = 0; b < lpcc_pkg::BOX_COUNT; b++) begin
         if (m_match[b]) begin
            group_mask[lpcc_pkg::skin_box(b).group] = 1'b1;
         end
      end
      kind_in = lpcc_pkg::KIND_SECTOR;
      mask_in = '0;
      hsec_in = '0;
      lsec_in = '0;
      if (m_side.gray) begin
         kind_in = lpcc_pkg::KIND_GRAY;
      end else if (group_mask != '0) begin
         kind_in = lpcc_pkg::KIND_SKIN;
         mask_in = group_mask;
      end else if (m_side.l_ge100) begin
         kind_in = lpcc_pkg::KIND_NONE;
      end else begin
         hsec_in = m_side.hue_sector;
         lsec_in = m_side.l_sector;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= m_valid;
      end
      if (advance) begin
         kind_ff <= kind_in;
         mask_ff <= mask_in;
         hsec_ff <= hsec_in;
         lsec_ff <= lsec_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_class_kind       = kind_ff;
   assign rsp_skin_mask        = mask_ff;
   assign rsp_hue_sector       = hsec_ff;
   assign rsp_lightness_sector = lsec_ff;

   a_gray_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_kind == lpcc_pkg::KIND_GRAY |->
         rsp_skin_mask == '0 && rsp_hue_sector == '0 && rsp_lightness_sector == '0)
      else $error("gray word carries stray fields");

   a_skin_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_kind == lpcc_pkg::KIND_SKIN |->
         rsp_skin_mask != '0 && rsp_hue_sector == '0 && rsp_lightness_sector == '0)
      else $error("skin word with empty mask or sectors");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_kind == lpcc_pkg::KIND_SECTOR |->
         rsp_skin_mask == '0 && rsp_hue_sector <= 4'd14 && rsp_lightness_sector <= 3'd4)
      else $error("sector word out of range");

endmodule
